/* hw/rtl/scancode_set1_key_event_queue_assert.svh */
// Assertion macros for the key event queue.
`ifndef SCANCODE_SET1_KEY_EVENT_QUEUE_ASSERT_SVH
`define SCANCODE_SET1_KEY_EVENT_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/skq_pkg.sv */
`default_nettype none

package skq_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  // Result status codes.
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_QUEUED  = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_POPPED  = 2'd3;

  // Item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Keycodes.
  localparam logic [3:0] KC_NONE  = 4'd0;
  localparam logic [3:0] KC_UP    = 4'd1;
  localparam logic [3:0] KC_DOWN  = 4'd2;
  localparam logic [3:0] KC_LEFT  = 4'd3;
  localparam logic [3:0] KC_RIGHT = 4'd4;
  localparam logic [3:0] KC_HOME  = 4'd5;
  localparam logic [3:0] KC_END   = 4'd6;
  localparam logic [3:0] KC_PGUP  = 4'd7;
  localparam logic [3:0] KC_PGDN  = 4'd8;
  localparam logic [3:0] KC_DEL   = 4'd9;
  localparam logic [3:0] KC_ENTER = 4'd10;
  localparam logic [3:0] KC_TAB   = 4'd11;
  localparam logic [3:0] KC_ESC   = 4'd12;

  // Scancodes (make codes are seven bits wide).
  localparam logic [7:0] SC_PREFIX  = 8'hE0;
  localparam logic [6:0] MK_LSHIFT  = 7'h2A;
  localparam logic [6:0] MK_RSHIFT  = 7'h36;
  localparam logic [6:0] MK_CTRL    = 7'h1D;
  localparam logic [6:0] MK_ALT     = 7'h38;
  localparam logic [6:0] MK_ENTER   = 7'h1C;
  localparam logic [6:0] MK_BKSP    = 7'h0E;
  localparam logic [6:0] MK_TAB     = 7'h0F;
  localparam logic [6:0] MK_ESC     = 7'h01;
  localparam logic [6:0] MK_UP      = 7'h48;
  localparam logic [6:0] MK_DOWN    = 7'h50;
  localparam logic [6:0] MK_LEFT    = 7'h4B;
  localparam logic [6:0] MK_RIGHT   = 7'h4D;
  localparam logic [6:0] MK_HOME    = 7'h47;
  localparam logic [6:0] MK_END     = 7'h4F;
  localparam logic [6:0] MK_PGUP    = 7'h49;
  localparam logic [6:0] MK_PGDN    = 7'h51;
  localparam logic [6:0] MK_DEL     = 7'h53;

  localparam logic [6:0] ASC_NONE = 7'h00;
  localparam logic [6:0] ASC_LF   = 7'h0A;
  localparam logic [6:0] ASC_BS   = 7'h08;
  localparam logic [6:0] ASC_HT   = 7'h09;

  localparam int unsigned TAB_LEN = 58;

  localparam logic [6:0] LOWER_TAB [TAB_LEN] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  localparam logic [6:0] UPPER_TAB [TAB_LEN] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] scan_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] ev_scancode;
    logic [6:0] ev_ascii;
    logic [3:0] ev_keycode;
    logic       ev_shift;
    logic       ev_ctrl;
    logic       ev_alt;
    logic       ev_extended;
    logic       pending;
  } rsp_t;

  // One queued key event as it is stored in the ring.
  typedef struct packed {
    logic       extended;
    logic       alt;
    logic       ctrl;
    logic       shift;
    logic [3:0] keycode;
    logic [6:0] ascii;
    logic [7:0] scancode;
  } event_t;

  function automatic logic [6:0] ascii_of(input logic [6:0] mk, input logic upper);
    logic [6:0] chr;
    chr = ASC_NONE;
    if (mk < 7'(TAB_LEN)) begin
      chr = upper ? UPPER_TAB[mk[5:0]] : LOWER_TAB[mk[5:0]];
    end
    return chr;
  endfunction

  function automatic logic [3:0] ext_keycode(input logic [6:0] mk);
    logic [3:0] kc;
    case (mk)
      MK_UP:    kc = KC_UP;
      MK_DOWN:  kc = KC_DOWN;
      MK_LEFT:  kc = KC_LEFT;
      MK_RIGHT: kc = KC_RIGHT;
      MK_HOME:  kc = KC_HOME;
      MK_END:   kc = KC_END;
      MK_PGUP:  kc = KC_PGUP;
      MK_PGDN:  kc = KC_PGDN;
      MK_DEL:   kc = KC_DEL;
      default:  kc = KC_NONE;
    endcase
    return kc;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/scancode_set1_key_event_queue.sv */
// Scancode byte items give their result in the cycle after acceptance and may follow
// every cycle while the result register is free or being taken. A pop of a non-empty
// queue reads the event ring into rd_data, then registers its result in S_READ; no new
// item is taken until S_READ is left. A pop of an empty queue answers like a byte item.
// Reset clears the pointers, modifier and prefix flags and the result valid flag;
// the ring contents are left as they are, since only written entries are read.
`default_nettype none

module scancode_set1_key_event_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                cmd_valid,
  output logic               cmd_ready,
  input  wire skq_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output skq_pkg::rsp_t      rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  localparam logic [skq_pkg::PTR_W-1:0] PTR_LAST =
    skq_pkg::PTR_W'(skq_pkg::QUEUE_DEPTH - 1);

  state_t                    state;
  logic [skq_pkg::PTR_W-1:0] wr_ptr;
  logic [skq_pkg::PTR_W-1:0] rd_ptr;
  logic                      shift_held;
  logic                      ctrl_held;
  logic                      alt_held;
  logic                      prefix_seen;

  logic                      shift_held_next;
  logic                      ctrl_held_next;
  logic                      alt_held_next;
  logic                      prefix_seen_next;
  logic [skq_pkg::PTR_W-1:0] wr_ptr_next;

  logic [skq_pkg::PTR_W-1:0] wr_inc;
  logic [skq_pkg::PTR_W-1:0] rd_inc;
  logic                      cmd_fire;
  logic                      is_pop;
  logic                      not_empty;
  logic                      pop_read;
  logic [6:0]                mk;
  logic                      mk_shift;
  logic [3:0]                ext_kc;
  logic                      want_push;
  logic                      ring_we;
  skq_pkg::event_t           new_ev;
  logic [1:0]                byte_status;

  skq_pkg::event_t           ring [skq_pkg::QUEUE_DEPTH];
  skq_pkg::event_t           rd_data;

  assign cmd_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign is_pop    = (cmd.kind == skq_pkg::KIND_POP);
  assign not_empty = (wr_ptr != rd_ptr);
  assign pop_read  = cmd_fire && is_pop && not_empty;

  assign wr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + skq_pkg::PTR_W'(1);
  assign rd_inc = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + skq_pkg::PTR_W'(1);

  assign mk       = cmd.scan_byte[6:0];
  assign mk_shift = (mk == skq_pkg::MK_LSHIFT) || (mk == skq_pkg::MK_RSHIFT);
  assign ext_kc   = skq_pkg::ext_keycode(mk);

  // Decode of one scancode byte: modifier and prefix tracking plus the event to queue.
  always_comb begin
    shift_held_next  = shift_held;
    ctrl_held_next   = ctrl_held;
    alt_held_next    = alt_held;
    prefix_seen_next = prefix_seen;
    want_push        = 1'b0;
    new_ev.extended  = 1'b0;
    new_ev.alt       = alt_held;
    new_ev.ctrl      = ctrl_held;
    new_ev.shift     = shift_held;
    new_ev.keycode   = skq_pkg::KC_NONE;
    new_ev.ascii     = skq_pkg::ASC_NONE;
    new_ev.scancode  = cmd.scan_byte;

    if (cmd.scan_byte == skq_pkg::SC_PREFIX) begin
      prefix_seen_next = 1'b1;
    end else if (cmd.scan_byte[7]) begin
      if (mk_shift) shift_held_next = 1'b0;
      if (mk == skq_pkg::MK_CTRL) ctrl_held_next = 1'b0;
      if (mk == skq_pkg::MK_ALT) alt_held_next = 1'b0;
      prefix_seen_next = 1'b0;
    end else if (prefix_seen) begin
      // Prefixed codes without a keycode are dropped silently.
      prefix_seen_next = 1'b0;
      want_push        = (ext_kc != skq_pkg::KC_NONE);
      new_ev.extended  = 1'b1;
      new_ev.keycode   = ext_kc;
      new_ev.scancode  = 8'h00;
    end else if (mk_shift) begin
      shift_held_next = 1'b1;
    end else if (mk == skq_pkg::MK_CTRL) begin
      ctrl_held_next = 1'b1;
    end else if (mk == skq_pkg::MK_ALT) begin
      alt_held_next = 1'b1;
    end else begin
      want_push = 1'b1;
      if (mk == skq_pkg::MK_ENTER) begin
        new_ev.keycode = skq_pkg::KC_ENTER;
        new_ev.ascii   = skq_pkg::ASC_LF;
      end else if (mk == skq_pkg::MK_BKSP) begin
        new_ev.ascii = skq_pkg::ASC_BS;
      end else if (mk == skq_pkg::MK_TAB) begin
        new_ev.keycode = skq_pkg::KC_TAB;
        new_ev.ascii   = skq_pkg::ASC_HT;
      end else if (mk == skq_pkg::MK_ESC) begin
        new_ev.keycode = skq_pkg::KC_ESC;
      end else begin
        new_ev.ascii = skq_pkg::ascii_of(mk, shift_held);
      end
    end

    // The ring keeps one entry free so that full and empty differ.
    ring_we     = 1'b0;
    wr_ptr_next = wr_ptr;
    byte_status = skq_pkg::ST_NONE;
    if (want_push) begin
      if (wr_inc == rd_ptr) begin
        byte_status = skq_pkg::ST_DROPPED;
      end else begin
        byte_status = skq_pkg::ST_QUEUED;
        ring_we     = cmd_fire && !is_pop;
        wr_ptr_next = wr_inc;
      end
    end
  end

  // A pop only reads entries whose write has already completed, so a read and
  // a write never meet on the same entry.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wr_ptr] <= new_ev;
    end
    if (pop_read) begin
      rd_data <= ring[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      shift_held  <= 1'b0;
      ctrl_held   <= 1'b0;
      alt_held    <= 1'b0;
      prefix_seen <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_fire && !pop_read) begin
            rsp_valid <= 1'b1;
          end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
          if (cmd_fire) begin
            if (is_pop) begin
              if (not_empty) begin
                rd_ptr <= rd_inc;
                state  <= S_READ;
              end
            end else begin
              shift_held  <= shift_held_next;
              ctrl_held   <= ctrl_held_next;
              alt_held    <= alt_held_next;
              prefix_seen <= prefix_seen_next;
              wr_ptr      <= wr_ptr_next;
            end
          end
        end
        S_READ: begin
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rsp.status      <= skq_pkg::ST_POPPED;
      rsp.ev_scancode <= rd_data.scancode;
      rsp.ev_ascii    <= rd_data.ascii;
      rsp.ev_keycode  <= rd_data.keycode;
      rsp.ev_shift    <= rd_data.shift;
      rsp.ev_ctrl     <= rd_data.ctrl;
      rsp.ev_alt      <= rd_data.alt;
      rsp.ev_extended <= rd_data.extended;
      rsp.pending     <= not_empty;
    end else if (cmd_fire && !pop_read) begin
      rsp.status      <= is_pop ? skq_pkg::ST_NONE : byte_status;
      rsp.ev_scancode <= 8'h00;
      rsp.ev_ascii    <= skq_pkg::ASC_NONE;
      rsp.ev_keycode  <= skq_pkg::KC_NONE;
      rsp.ev_shift    <= 1'b0;
      rsp.ev_ctrl     <= 1'b0;
      rsp.ev_alt      <= 1'b0;
      rsp.ev_extended <= 1'b0;
      rsp.pending     <= is_pop ? 1'b0 : (wr_ptr_next != rd_ptr);
    end
  end

`include "scancode_set1_key_event_queue_assert.svh"

  `SKQ_ASSERT_SAME(a_read_slot_free, clk, rst, state == S_READ, !rsp_valid,
    "output register busy while a ring read is in flight")
  `SKQ_ASSERT_NEXT(a_pop_reads, clk, rst, pop_read, state == S_READ,
    "pop of a non-empty queue did not start a ring read")
  `SKQ_ASSERT_NEXT(a_read_delivers, clk, rst, state == S_READ,
    rsp_valid && (rsp.status == skq_pkg::ST_POPPED),
    "ring read did not produce a popped result")

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Character maps for plain make codes, unshifted and shifted.
  localparam int unsigned MAP_LEN = 58;

  localparam logic [6:0] PLAIN_CHARS [MAP_LEN] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  localparam logic [6:0] SHIFTED_CHARS [MAP_LEN] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  localparam logic [6:0] NAV_MAKES [9] = '{
    skq_pkg::MK_UP, skq_pkg::MK_DOWN, skq_pkg::MK_LEFT, skq_pkg::MK_RIGHT,
    skq_pkg::MK_HOME, skq_pkg::MK_END, skq_pkg::MK_PGUP, skq_pkg::MK_PGDN,
    skq_pkg::MK_DEL
  };

  localparam logic [6:0] MOD_MAKES [4] = '{
    skq_pkg::MK_LSHIFT, skq_pkg::MK_RSHIFT, skq_pkg::MK_CTRL, skq_pkg::MK_ALT
  };

  localparam int unsigned PHASE_ITEMS = 410;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 8;

  class key_event_board;
    skq_pkg::rsp_t             expected_q[$];
    skq_pkg::event_t           ring [skq_pkg::QUEUE_DEPTH];
    logic [skq_pkg::PTR_W-1:0] wr_ptr;
    logic [skq_pkg::PTR_W-1:0] rd_ptr;
    bit                        shift_on;
    bit                        ctrl_on;
    bit                        alt_on;
    bit                        prefix_on;
    int unsigned               failures;
    int unsigned               n_items;
    int unsigned               n_queued;
    int unsigned               n_dropped;
    int unsigned               n_popped;
    int unsigned               n_empty_pops;

    function new();
      wr_ptr = '0;
      rd_ptr = '0;
      shift_on = 0;
      ctrl_on = 0;
      alt_on = 0;
      prefix_on = 0;
      failures = 0;
      n_items = 0;
      n_queued = 0;
      n_dropped = 0;
      n_popped = 0;
      n_empty_pops = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    function string show(skq_pkg::rsp_t r);
      return $sformatf("st=%0d sc=%02h asc=%02h kc=%0d sh=%0b ct=%0b al=%0b ext=%0b pend=%0b",
                       r.status, r.ev_scancode, r.ev_ascii, r.ev_keycode, r.ev_shift,
                       r.ev_ctrl, r.ev_alt, r.ev_extended, r.pending);
    endfunction

    function logic [3:0] nav_keycode(logic [6:0] mk);
      case (mk)
        skq_pkg::MK_UP:    return skq_pkg::KC_UP;
        skq_pkg::MK_DOWN:  return skq_pkg::KC_DOWN;
        skq_pkg::MK_LEFT:  return skq_pkg::KC_LEFT;
        skq_pkg::MK_RIGHT: return skq_pkg::KC_RIGHT;
        skq_pkg::MK_HOME:  return skq_pkg::KC_HOME;
        skq_pkg::MK_END:   return skq_pkg::KC_END;
        skq_pkg::MK_PGUP:  return skq_pkg::KC_PGUP;
        skq_pkg::MK_PGDN:  return skq_pkg::KC_PGDN;
        skq_pkg::MK_DEL:   return skq_pkg::KC_DEL;
        default:           return skq_pkg::KC_NONE;
      endcase
    endfunction

    // The slot just behind the read pointer stays empty, so the ring holds one
    // event fewer than its depth.
    function logic [1:0] store(logic [7:0] sc, logic [6:0] chr, logic [3:0] kc, bit ext);
      logic [skq_pkg::PTR_W-1:0] nxt;
      skq_pkg::event_t           e;
      nxt = wr_ptr + 1'b1;
      if (nxt == rd_ptr) begin
        return skq_pkg::ST_DROPPED;
      end
      e.scancode = sc;
      e.ascii    = chr;
      e.keycode  = kc;
      e.shift    = shift_on;
      e.ctrl     = ctrl_on;
      e.alt      = alt_on;
      e.extended = ext;
      ring[wr_ptr] = e;
      wr_ptr = nxt;
      return skq_pkg::ST_QUEUED;
    endfunction

    function logic [1:0] take_scan(logic [7:0] b);
      logic [6:0] mk;
      logic [3:0] kc;
      logic [6:0] chr;
      mk = b[6:0];
      if (b == skq_pkg::SC_PREFIX) begin
        prefix_on = 1;
        return skq_pkg::ST_NONE;
      end
      if (b[7]) begin
        if (mk == skq_pkg::MK_LSHIFT || mk == skq_pkg::MK_RSHIFT) shift_on = 0;
        if (mk == skq_pkg::MK_CTRL) ctrl_on = 0;
        if (mk == skq_pkg::MK_ALT) alt_on = 0;
        prefix_on = 0;
        return skq_pkg::ST_NONE;
      end
      if (prefix_on) begin
        // Unknown prefixed codes, fake shifts among them, vanish here.
        prefix_on = 0;
        kc = nav_keycode(mk);
        if (kc == skq_pkg::KC_NONE) begin
          return skq_pkg::ST_NONE;
        end
        return store(8'h00, skq_pkg::ASC_NONE, kc, 1'b1);
      end
      if (mk == skq_pkg::MK_LSHIFT || mk == skq_pkg::MK_RSHIFT) begin
        shift_on = 1;
        return skq_pkg::ST_NONE;
      end
      if (mk == skq_pkg::MK_CTRL) begin
        ctrl_on = 1;
        return skq_pkg::ST_NONE;
      end
      if (mk == skq_pkg::MK_ALT) begin
        alt_on = 1;
        return skq_pkg::ST_NONE;
      end
      case (mk)
        skq_pkg::MK_ENTER: begin
          kc = skq_pkg::KC_ENTER;
          chr = skq_pkg::ASC_LF;
        end
        skq_pkg::MK_BKSP: begin
          kc = skq_pkg::KC_NONE;
          chr = skq_pkg::ASC_BS;
        end
        skq_pkg::MK_TAB: begin
          kc = skq_pkg::KC_TAB;
          chr = skq_pkg::ASC_HT;
        end
        skq_pkg::MK_ESC: begin
          kc = skq_pkg::KC_ESC;
          chr = skq_pkg::ASC_NONE;
        end
        default: begin
          kc = skq_pkg::KC_NONE;
          chr = skq_pkg::ASC_NONE;
          if (mk < 7'(MAP_LEN)) begin
            chr = shift_on ? SHIFTED_CHARS[mk[5:0]] : PLAIN_CHARS[mk[5:0]];
          end
        end
      endcase
      return store(b, chr, kc, 1'b0);
    endfunction

    function void note_cmd(skq_pkg::cmd_t c);
      skq_pkg::rsp_t   r;
      skq_pkg::event_t e;
      r = '0;
      n_items++;
      if (c.kind == skq_pkg::KIND_POP) begin
        if (wr_ptr != rd_ptr) begin
          e = ring[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          r.status      = skq_pkg::ST_POPPED;
          r.ev_scancode = e.scancode;
          r.ev_ascii    = e.ascii;
          r.ev_keycode  = e.keycode;
          r.ev_shift    = e.shift;
          r.ev_ctrl     = e.ctrl;
          r.ev_alt      = e.alt;
          r.ev_extended = e.extended;
          n_popped++;
        end else begin
          n_empty_pops++;
        end
      end else begin
        r.status = take_scan(c.scan_byte);
        if (r.status == skq_pkg::ST_QUEUED) n_queued++;
        if (r.status == skq_pkg::ST_DROPPED) n_dropped++;
      end
      r.pending = (wr_ptr != rd_ptr);
      expected_q.push_back(r);
    endfunction

    function void check_rsp(skq_pkg::rsp_t got);
      skq_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with nothing expected: %s", show(got)));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        flag($sformatf("expected %s, got %s", show(want), show(got)));
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void flush_leftovers();
      while (expected_q.size() > 0) begin
        flag($sformatf("result never arrived: %s", show(expected_q.pop_front())));
      end
    endfunction
  endclass

  logic          clk;
  logic          rst = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  skq_pkg::cmd_t cmd = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  skq_pkg::rsp_t rsp;

  key_event_board board = new();
  skq_pkg::cmd_t  item_plan[$];
  int             rcv_idle_pct = 0;
  int             hold_left = 0;

  scancode_set1_key_event_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) board.check_rsp(rsp);
      if (cmd_valid && cmd_ready) board.note_cmd(cmd);
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_left counts down.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  function automatic void plan_byte(logic [7:0] b);
    skq_pkg::cmd_t c;
    c.kind = skq_pkg::KIND_BYTE;
    c.scan_byte = b;
    item_plan.push_back(c);
  endfunction

  // The byte field of a pop is ignored, so it carries random bits.
  function automatic void plan_pop();
    skq_pkg::cmd_t c;
    c.kind = skq_pkg::KIND_POP;
    c.scan_byte = 8'($urandom_range(255));
    item_plan.push_back(c);
  endfunction

  function automatic void plan_directed();
    plan_pop();
    plan_byte(skq_pkg::SC_PREFIX); plan_byte({1'b0, skq_pkg::MK_UP});
    plan_byte({1'b1, skq_pkg::MK_UP});
    plan_byte(skq_pkg::SC_PREFIX); plan_byte({1'b0, skq_pkg::MK_LSHIFT});
    plan_byte({1'b0, skq_pkg::MK_LSHIFT}); plan_byte(8'h1E);
    plan_byte({1'b1, skq_pkg::MK_LSHIFT});
    plan_byte({1'b0, skq_pkg::MK_CTRL}); plan_byte({1'b0, skq_pkg::MK_ALT});
    plan_byte(8'h02);
    plan_byte({1'b1, skq_pkg::MK_CTRL}); plan_byte({1'b1, skq_pkg::MK_ALT});
    plan_byte({1'b0, skq_pkg::MK_ENTER}); plan_byte({1'b0, skq_pkg::MK_BKSP});
    plan_byte({1'b0, skq_pkg::MK_TAB}); plan_byte({1'b0, skq_pkg::MK_ESC});
    plan_byte(8'h7F); plan_byte(8'h00); plan_byte(8'hE1); plan_byte(8'hFF);
    plan_byte({1'b0, skq_pkg::MK_RSHIFT}); plan_byte({1'b0, skq_pkg::MK_DEL});
    plan_byte({1'b1, skq_pkg::MK_RSHIFT});
  endfunction

  // Mostly well-formed key gestures, with pop density switching between
  // filling and draining the ring, plus stray break codes and raw noise.
  function automatic void plan_random(int unsigned n);
    int unsigned target;
    int unsigned pop_pct;
    int unsigned since_flip;
    int unsigned flip_at;
    int unsigned pick;
    logic [6:0]  mk;
    logic [6:0]  mod;
    target = item_plan.size() + n;
    pop_pct = 10;
    since_flip = 0;
    flip_at = $urandom_range(120, 180);
    while (item_plan.size() < target) begin
      if (since_flip >= flip_at) begin
        pop_pct = (pop_pct == 10) ? 65 : 10;
        since_flip = 0;
        flip_at = $urandom_range(120, 180);
      end
      pick = $urandom_range(99);
      if ($urandom_range(99) < pop_pct) begin
        plan_pop();
        since_flip += 1;
      end else if (pick < 45) begin
        mk = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(57));
        plan_byte({1'b0, mk});
        if ($urandom_range(3) != 0) plan_byte({1'b1, mk});
        since_flip += 2;
      end else if (pick < 60) begin
        mod = MOD_MAKES[2'($urandom_range(3))];
        mk = 7'($urandom_range(57));
        plan_byte({1'b0, mod});
        plan_byte({1'b0, mk});
        if ($urandom_range(9) < 6) plan_byte({1'b1, mod});
        since_flip += 3;
      end else if (pick < 80) begin
        mk = ($urandom_range(4) != 0) ? NAV_MAKES[4'($urandom_range(8))]
                                      : 7'($urandom_range(127));
        plan_byte(skq_pkg::SC_PREFIX);
        plan_byte({1'b0, mk});
        if ($urandom_range(9) < 6) begin
          plan_byte(skq_pkg::SC_PREFIX);
          plan_byte({1'b1, mk});
        end
        since_flip += 3;
      end else if (pick < 92) begin
        plan_byte(8'($urandom_range(128, 255)));
        since_flip += 1;
      end else begin
        plan_byte(8'($urandom_range(255)));
        since_flip += 1;
      end
    end
  endfunction

  task automatic send_plan(input int unsigned idle_pct);
    skq_pkg::cmd_t c;
    while (item_plan.size() > 0) begin
      c = item_plan.pop_front();
      while ($urandom_range(99) < idle_pct) begin
        cmd_valid <= 1'b0;
        @(posedge clk);
      end
      cmd <= c;
      cmd_valid <= 1'b1;
      @(posedge clk);
      while (!cmd_ready) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    rcv_idle_pct = 75;
    plan_directed();
    plan_random(PHASE_ITEMS);
    send_plan(31);

    rcv_idle_pct = 31;
    plan_random(PHASE_ITEMS);
    send_plan(75);

    // No idling here; the receiver first stalls long enough to back up the input.
    rcv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    plan_random(PHASE_ITEMS);
    send_plan(0);

    cmd_valid <= 1'b0;
    waited = 0;
    while (board.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    board.flush_leftovers();

    $display("Ran %0d items: %0d events queued, %0d dropped on a full ring,",
             board.n_items, board.n_queued, board.n_dropped);
    $display("%0d events popped and %0d pops of an empty ring; %0d failures.",
             board.n_popped, board.n_empty_pops, board.failures);
    if (board.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
